// ===== rtl/bmhq_pkg.sv =====
package bmhq_pkg;

   // Heap capacity and derived widths
   localparam int DEPTH     = 1024;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CH_W      = ADDR_W + 2;
   localparam int KEY_W     = 32;
   localparam int OUT_CNT_W = 11;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [CH_W-1:0]         child_type;

   // Action codes
   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_PEEK = 2'd2;

   localparam key_type KEY_EMPTY = '1;
   localparam key_type KEY_NONE  = '0;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_ROOT,
      ST_POP_LAST,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_RESP
   } state_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_TAKE_ROOT,
      OP_TAKE_LAST,
      OP_DN_PLACE,
      OP_DN_READ_L,
      OP_DN_READ_R,
      OP_DN_STEP,
      OP_UP_PLACE,
      OP_UP_READ,
      OP_UP_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic is_pop;
      logic last_one;
      logic idx_zero;
      logic left_in;
      logic up_stop;
      logic dn_stop;
   } dp_stat_type;

   // Count as reported on the result port, zero-extended or masked
   function automatic logic [OUT_CNT_W-1:0] count_out(input count_type c);
      logic [CNT_W+OUT_CNT_W-1:0] wide;
      wide = {{OUT_CNT_W{1'b0}}, c};
      return wide[OUT_CNT_W-1:0];
   endfunction

endpackage

// ===== rtl/bmhq_ram.sv =====
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bmhq_dp.sv =====
module bmhq_dp
   import bmhq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic [1:0]           req_action,
   input  key_type              req_key_in,
   output key_type              rsp_key_out,
   output logic                 rsp_was_empty,
   output logic                 rsp_push_dropped,
   output logic [OUT_CNT_W-1:0] rsp_entry_count
);

   count_type  count_ff, count_in;
   addr_type   idx_ff, idx_in;
   key_type    key_ff, key_in;
   key_type    lkey_ff, lkey_in;
   key_type    root_ff, root_in;
   logic [1:0] act_ff, act_in;
   logic       empty_ff, empty_in;
   logic       dropped_ff, dropped_in;

   logic              wr_en, rd_en;
   addr_type          wr_addr, rd_addr;
   logic [KEY_W-1:0]  wr_data, rd_data;
   key_type           rkey;

   logic      full, empty;
   addr_type  parent, last_addr;
   count_type count_m1;
   child_type left, right, count_ext;
   logic      left_in, right_in;
   logic      up_gt, l_gt, r_gt;
   key_type   pick_key;

   bmhq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rkey = rd_data;

   // Index arithmetic
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign count_m1  = count_ff - 1'b1;
   assign last_addr = count_m1[ADDR_W-1:0];
   assign parent    = (idx_ff - 1'b1) >> 1;
   assign left      = {1'b0, idx_ff, 1'b1};
   assign right     = {1'b0, idx_ff, 1'b0} + CH_W'(2);
   assign count_ext = CH_W'(count_ff);
   assign left_in   = (left < count_ext);
   assign right_in  = (right < count_ext);

   // Key compares: hole key against parent, left child against hole key, right child against the larger of the two
   assign up_gt    = (key_ff > rkey);
   assign l_gt     = (lkey_ff > key_ff);
   assign pick_key = l_gt ? lkey_ff : key_ff;
   assign r_gt     = right_in && (rkey > pick_key);

   // Memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = key_ff;
      rd_en   = 1'b0;
      rd_addr = '0;
      unique case (cmd.op)
         OP_ACCEPT: begin
            rd_en = 1'b1;
         end
         OP_TAKE_ROOT: begin
            rd_en   = (act_ff == ACT_POP);
            rd_addr = last_addr;
         end
         OP_DN_PLACE, OP_UP_PLACE: begin
            wr_en = 1'b1;
         end
         OP_DN_READ_L: begin
            rd_en   = 1'b1;
            rd_addr = left[ADDR_W-1:0];
         end
         OP_DN_READ_R: begin
            rd_en   = right_in;
            rd_addr = right[ADDR_W-1:0];
         end
         OP_DN_STEP: begin
            wr_en = 1'b1;
            if (r_gt) begin
               wr_data = rkey;
            end else begin
               wr_data = pick_key;
            end
         end
         OP_UP_READ: begin
            rd_en   = 1'b1;
            rd_addr = parent;
         end
         OP_UP_STEP: begin
            wr_en   = 1'b1;
            wr_data = up_gt ? rkey : key_ff;
         end
         OP_TAKE_LAST, OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   // Register next values
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      lkey_in    = lkey_ff;
      root_in    = root_ff;
      act_in     = act_ff;
      empty_in   = empty_ff;
      dropped_in = dropped_ff;
      unique case (cmd.op)
         OP_ACCEPT: begin
            act_in     = req_action;
            key_in     = req_key_in;
            dropped_in = (req_action == ACT_PUSH) && full;
            empty_in   = ((req_action == ACT_POP) || (req_action == ACT_PEEK)) && empty;
            root_in    = (((req_action == ACT_POP) || (req_action == ACT_PEEK)) && empty)
                         ? KEY_EMPTY : KEY_NONE;
            if ((req_action == ACT_PUSH) && !full) begin
               idx_in   = count_ff[ADDR_W-1:0];
               count_in = count_ff + 1'b1;
            end
         end
         OP_TAKE_ROOT: begin
            root_in = rkey;
            if (act_ff == ACT_POP) begin
               count_in = count_m1;
            end
         end
         OP_TAKE_LAST: begin
            key_in = rkey;
            idx_in = '0;
         end
         OP_DN_READ_R: begin
            lkey_in = rkey;
         end
         OP_DN_STEP: begin
            if (r_gt) begin
               idx_in = right[ADDR_W-1:0];
            end else if (l_gt) begin
               idx_in = left[ADDR_W-1:0];
            end
         end
         OP_UP_STEP: begin
            if (up_gt) begin
               idx_in = parent;
            end
         end
         OP_DN_PLACE, OP_DN_READ_L, OP_UP_PLACE, OP_UP_READ, OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      key_ff     <= key_in;
      lkey_ff    <= lkey_in;
      root_ff    <= root_in;
      act_ff     <= act_in;
      empty_ff   <= empty_in;
      dropped_ff <= dropped_in;
   end

   // Status back to the controller
   assign stat.empty    = empty;
   assign stat.full     = full;
   assign stat.is_pop   = (act_ff == ACT_POP);
   assign stat.last_one = (count_ff == CNT_W'(1));
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.left_in  = left_in;
   assign stat.up_stop  = !up_gt;
   assign stat.dn_stop  = !r_gt && !l_gt;

   assign rsp_key_out      = root_ff;
   assign rsp_was_empty    = empty_ff;
   assign rsp_push_dropped = dropped_ff;
   assign rsp_entry_count  = count_out(count_ff);

endmodule

// ===== rtl/bmhq_ctrl.sv =====
module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_action,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (req_action == ACT_PUSH) begin
                  state_in = stat.full ? ST_RESP : ST_PUSH_RD;
               end else if ((req_action == ACT_POP) || (req_action == ACT_PEEK)) begin
                  state_in = stat.empty ? ST_RESP : ST_POP_ROOT;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_POP_ROOT: begin
            state_in = (!stat.is_pop || stat.last_one) ? ST_RESP : ST_POP_LAST;
         end
         ST_POP_LAST: state_in = ST_DN_RDL;
         ST_DN_RDL:   state_in = stat.left_in ? ST_DN_RDR : ST_RESP;
         ST_DN_RDR:   state_in = ST_DN_CMP;
         ST_DN_CMP:   state_in = stat.dn_stop ? ST_RESP : ST_DN_RDL;
         ST_PUSH_RD:  state_in = stat.idx_zero ? ST_RESP : ST_PUSH_CMP;
         ST_PUSH_CMP: state_in = stat.up_stop ? ST_RESP : ST_PUSH_RD;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd.op    = OP_NONE;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op = OP_ACCEPT;
            end
         end
         ST_POP_ROOT: cmd.op = OP_TAKE_ROOT;
         ST_POP_LAST: cmd.op = OP_TAKE_LAST;
         ST_DN_RDL:   cmd.op = stat.left_in ? OP_DN_READ_L : OP_DN_PLACE;
         ST_DN_RDR:   cmd.op = OP_DN_READ_R;
         ST_DN_CMP:   cmd.op = OP_DN_STEP;
         ST_PUSH_RD:  cmd.op = stat.idx_zero ? OP_UP_PLACE : OP_UP_READ;
         ST_PUSH_CMP: cmd.op = OP_UP_STEP;
         ST_RESP:     rsp_valid = 1'b1;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

// ===== rtl/binary_max_heap_queue.sv =====
// Channel   Ports                                   Transfer
// -------   -------------------------------------   ------------------------------
// request   start, busy, req_action, req_key_in    rising edge with start & !busy
// response  rsp_valid, rsp_key_out, rsp_was_empty,  one cycle while rsp_valid high
//           rsp_push_dropped, rsp_entry_count
//
// One item at a time; busy stays high from acceptance until the response cycle ends.
// Push climbs toward the root and stops early at a parent that is not smaller than the key.
// Pop sinks toward a leaf and stops early when neither child is larger, reading the children through
// the single read port of the key store. Peek, last-key pop, empty, full push and no-op do neither.
// Synchronous reset empties the heap at once; the key store itself is not cleared.
// The receiver cannot stall: each response is shown for exactly one cycle.
module binary_max_heap_queue
   import bmhq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_action,
   input  key_type              req_key_in,
   output logic                 rsp_valid,
   output key_type              rsp_key_out,
   output logic                 rsp_was_empty,
   output logic                 rsp_push_dropped,
   output logic [OUT_CNT_W-1:0] rsp_entry_count
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   bmhq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_key_in       (req_key_in),
      .rsp_key_out      (rsp_key_out),
      .rsp_was_empty    (rsp_was_empty),
      .rsp_push_dropped (rsp_push_dropped),
      .rsp_entry_count  (rsp_entry_count)
   );

   // A response ends the item: the block is ready again next cycle
   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after response");

   // An accepted request keeps the block busy on the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // An empty-heap response carries the empty key and no drop flag
   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_empty) |-> (rsp_key_out == KEY_EMPTY && !rsp_push_dropped))
      else $error("empty response with wrong key or drop flag");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   import bmhq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Unused action code: the block answers with the unchanged count
   localparam logic [1:0] ACT_NOP = 2'd3;

   localparam int unsigned CYCLE_LIMIT  = 600_000;
   localparam int          DRAIN_CYCLES = 64;
   localparam int          PRINT_CAP    = 30;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_action;
   key_type              req_key_in;
   logic                 rsp_valid;
   key_type              rsp_key_out;
   logic                 rsp_was_empty;
   logic                 rsp_push_dropped;
   logic [OUT_CNT_W-1:0] rsp_entry_count;

   int unsigned cycle_count = 0;

   // One response as the block should present it
   typedef struct {
      key_type              key;
      logic                 was_empty;
      logic                 dropped;
      logic [OUT_CNT_W-1:0] count;
   } heap_rsp_type;

   // Mirror of the heap: predicts each response and checks the block against it
   class heap_mirror_type;
      key_type      mirror_keys[DEPTH];
      int           mirror_fill;
      heap_rsp_type awaited_rsp[$];
      int           mismatches;
      int           checked_cnt;
      int           push_cnt, pop_cnt, peek_cnt, nop_cnt;
      int           drop_cnt, empty_cnt, peak_fill;

      function new();
         mirror_fill = 0;
         mismatches  = 0;
         checked_cnt = 0;
         push_cnt    = 0;
         pop_cnt     = 0;
         peek_cnt    = 0;
         nop_cnt     = 0;
         drop_cnt    = 0;
         empty_cnt   = 0;
         peak_fill   = 0;
      endfunction

      function void swap_keys(int a, int b);
         key_type t;
         t              = mirror_keys[a];
         mirror_keys[a] = mirror_keys[b];
         mirror_keys[b] = t;
      endfunction

      // Advance the mirror by one accepted request and queue its response
      function void note_request(logic [1:0] act, key_type key);
         heap_rsp_type rsp;
         int           idx;
         int           parent;
         int           pick;
         int           left;
         rsp.key       = KEY_NONE;
         rsp.was_empty = 1'b0;
         rsp.dropped   = 1'b0;
         case (act)
            ACT_PUSH: begin
               push_cnt++;
               if (mirror_fill >= DEPTH) begin
                  rsp.dropped = 1'b1;
                  drop_cnt++;
               end else begin
                  idx              = mirror_fill;
                  mirror_keys[idx] = key;
                  mirror_fill++;
                  // climb while the parent is strictly smaller
                  while (idx != 0) begin
                     parent = (idx - 1) / 2;
                     if (!(mirror_keys[idx] > mirror_keys[parent]))
                        break;
                     swap_keys(idx, parent);
                     idx = parent;
                  end
               end
            end
            ACT_POP, ACT_PEEK: begin
               if (act == ACT_POP)
                  pop_cnt++;
               else
                  peek_cnt++;
               if (mirror_fill == 0) begin
                  rsp.key       = KEY_EMPTY;
                  rsp.was_empty = 1'b1;
                  empty_cnt++;
               end else begin
                  rsp.key = mirror_keys[0];
                  if (act == ACT_POP) begin
                     mirror_fill--;
                     if (mirror_fill > 0) begin
                        mirror_keys[0] = mirror_keys[mirror_fill];
                        idx = 0;
                        // sink: left child first, right only if strictly above the pick
                        while (1) begin
                           pick = idx;
                           left = 2 * idx + 1;
                           if (left < mirror_fill && mirror_keys[left] > mirror_keys[pick])
                              pick = left;
                           if (left + 1 < mirror_fill &&
                               mirror_keys[left + 1] > mirror_keys[pick])
                              pick = left + 1;
                           if (pick == idx)
                              break;
                           swap_keys(idx, pick);
                           idx = pick;
                        end
                     end
                  end
               end
            end
            default: nop_cnt++;
         endcase
         rsp.count = OUT_CNT_W'(mirror_fill);
         if (mirror_fill > peak_fill)
            peak_fill = mirror_fill;
         awaited_rsp.push_back(rsp);
      endfunction

      task report_mismatch(string what, logic signed [63:0] got, logic signed [63:0] want);
         if (mismatches < PRINT_CAP)
            $display("%0t: mismatch on %s, got %0d, want %0d", $time, what, got, want);
         mismatches++;
      endtask

      // Compare one response transfer with the oldest prediction
      task check_response(key_type key, logic was_empty, logic dropped,
                          logic [OUT_CNT_W-1:0] count);
         heap_rsp_type want;
         checked_cnt++;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("response with no request pending", 0, 0);
            return;
         end
         want = awaited_rsp.pop_front();
         if (key !== want.key)
            report_mismatch("key_out", key, want.key);
         if (was_empty !== want.was_empty)
            report_mismatch("was_empty", was_empty, want.was_empty);
         if (dropped !== want.dropped)
            report_mismatch("push_dropped", dropped, want.dropped);
         if (count !== want.count)
            report_mismatch("entry_count", count, want.count);
      endtask
   endclass

   heap_mirror_type mirror;

   binary_max_heap_queue DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_key_in       (req_key_in),
      .rsp_valid        (rsp_valid),
      .rsp_key_out      (rsp_key_out),
      .rsp_was_empty    (rsp_was_empty),
      .rsp_push_dropped (rsp_push_dropped),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         mirror.check_response(rsp_key_out, rsp_was_empty, rsp_push_dropped, rsp_entry_count);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, mirror.awaited_rsp.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Extremes, runs of duplicates near zero, and full-width random keys
   function automatic key_type pick_key();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return KEY_EMPTY;
         3, 4, 5: return key_type'(int'($urandom_range(12)) - 6);
         default: return key_type'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_action(int push_pct);
      int r;
      r = $urandom_range(99);
      if (r < push_pct)
         return ACT_PUSH;
      else if (r < 97)
         return ($urandom_range(2) != 0) ? ACT_POP : ACT_PEEK;
      else
         return ACT_NOP;
   endfunction

   // One request transfer, preceded by a random number of idle cycles
   task automatic send_request(input logic [1:0] act, input key_type key, input int idle_pct);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= act;
      req_key_in <= key;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      mirror.note_request(act, key);
   endtask

   task automatic run_mix(input int n_items, input int push_pct, input int idle_pct);
      for (int i = 0; i < n_items; i++)
         send_request(pick_action(push_pct), pick_key(), idle_pct);
   endtask

   initial begin
      mirror = new();
      reset      <= 1'b1;
      start      <= 1'b0;
      req_action <= ACT_PUSH;
      req_key_in <= KEY_NONE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-heap reads, no-ops, extreme and duplicate keys
      send_request(ACT_PEEK, 32'sh1234_5678, 0);
      send_request(ACT_POP,  32'sh7FFF_FFFF, 0);
      send_request(ACT_NOP,  32'sh5555_5555, 0);
      send_request(ACT_PUSH, 32'sh8000_0000, 0);
      send_request(ACT_PUSH, 32'sh7FFF_FFFF, 0);
      send_request(ACT_PUSH, KEY_EMPTY, 0);
      send_request(ACT_PUSH, KEY_NONE, 0);
      send_request(ACT_PUSH, 32'sh7FFF_FFFF, 0);
      send_request(ACT_PEEK, KEY_EMPTY, 0);
      send_request(ACT_NOP,  32'shAAAA_AAAA, 0);
      send_request(ACT_POP,  KEY_NONE, 0);
      send_request(ACT_POP,  KEY_NONE, 0);
      send_request(ACT_PUSH, 32'sh0000_0001, 0);
      send_request(ACT_PUSH, 32'shFFFF_FFFE, 0);
      for (int i = 0; i < 7; i++)
         send_request(ACT_POP, KEY_EMPTY, 0);
      send_request(ACT_PUSH, 32'sh5555_5555, 0);
      send_request(ACT_PUSH, 32'shAAAA_AAAA, 0);
      send_request(ACT_PEEK, 32'sh0F0F_0F0F, 0);
      send_request(ACT_POP,  KEY_NONE, 0);

      // Small heaps that often run empty, sender gaps first light then heavy
      run_mix(80, 56, 28);
      run_mix(80, 52, 70);

      // Back to back: fill to capacity, push against a full heap, then drain part
      while (mirror.mirror_fill < DEPTH)
         send_request(pick_action(98), pick_key(), 0);
      for (int i = 0; i < 12; i++)
         send_request((i % 3 == 2) ? ACT_PEEK : ACT_PUSH, pick_key(), 0);
      send_request(ACT_NOP, pick_key(), 0);
      run_mix(40, 30, 0);

      start <= 1'b0;
      while (mirror.awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d pushes (%0d dropped when full), %0d pops, %0d peeks, %0d no-ops",
               mirror.push_cnt, mirror.drop_cnt, mirror.pop_cnt, mirror.peek_cnt,
               mirror.nop_cnt);
      $display("%0d responses checked, %0d reads of an empty heap, peak fill %0d of %0d",
               mirror.checked_cnt, mirror.empty_cnt, mirror.peak_fill, DEPTH);
      if (mirror.mismatches == 0 && mirror.awaited_rsp.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
